[src/mtg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, constants and helper functions shared by the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int unsigned MT_N = 624;
    localparam int unsigned MT_M = 397;
    localparam int unsigned IDX_W = 10;

    localparam logic [31:0] MATRIX_A    = 32'h9908_b0df;
    localparam logic [31:0] FILL_MULT   = 32'd1812433253;
    localparam logic [31:0] MIX1_MULT   = 32'd1664525;
    localparam logic [31:0] MIX2_MULT   = 32'd1566083941;
    localparam logic [31:0] BASE_SEED   = 32'd19650218;
    localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;
    localparam logic [31:0] WORD0_FINAL = 32'h8000_0000;

    localparam logic KIND_RANDOM = 1'b0;
    localparam logic KIND_STATE  = 1'b1;

    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_GEN   = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_MUL,
        ST_FILL_WR,
        ST_MIX_RD,
        ST_MIX_WR,
        ST_MIX_WRAP,
        ST_SEED_END,
        ST_TW_RD0,
        ST_TW_RD1,
        ST_TW_RD2,
        ST_TW_WR,
        ST_GEN_RD,
        ST_GEN_OUT,
        ST_READ_RD,
        ST_READ_OUT
    } t_state;

    function automatic logic [31:0] scramble(input logic [31:0] p);
        scramble = p ^ (p >> 30);
    endfunction

endpackage

`default_nettype wire

[src/mtg_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_cmd_if / mtg_res_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface mtg_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] data_word;
    logic        key_last;
    logic [9:0]  state_index;

    modport source (output valid, command, data_word, key_last, state_index, input ready);
    modport sink   (input valid, command, data_word, key_last, state_index, output ready);
endinterface

interface mtg_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_word;
    logic        result_kind;

    modport source (output valid, result_word, result_kind, input ready);
    modport sink   (input valid, result_word, result_kind, output ready);
endinterface

`default_nettype wire

[src/mtg_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    parameter int AW    = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/mtg_temper.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_temper
// Output tempering of one state word.
// ----------------------------------------------------------------------------
module mtg_temper (
    input  wire logic [31:0] i_word,
    output logic      [31:0] o_word
);

    logic [31:0] y1;
    logic [31:0] y2;
    logic [31:0] y3;

    always_comb begin
        y1     = i_word ^ (i_word >> 11);
        y2     = y1 ^ ((y1 << 7) & mtg_pkg::TEMPER_B);
        y3     = y2 ^ ((y2 << 15) & mtg_pkg::TEMPER_C);
        o_word = y3 ^ (y3 >> 18);
    end

endmodule

`default_nettype wire

[src/mt19937_generator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mt19937_generator_unit
// MT19937 generator with key-array seeding over a 624-word state RAM.
// ----------------------------------------------------------------------------
// Takes one command beat at a time. The 624-word state sits in a RAM with one
// write and one registered read port. A state or position write is done as
// its beat is taken; a read runs READ_RD, READ_OUT and a draw GEN_RD, GEN_OUT,
// after a full twist (TW_RD0 to TW_WR per word) if the position has reached
// 624. A key word is stored; the final one runs the seeding: fill, a mix pass
// over max(624, keys) words, a second over 623 and the word-0 write. A result
// waits in an output register without blocking the next command beat.
module mt19937_generator_unit #(
    parameter int KEY_DEPTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mtg_cmd_if.sink    i_cmd,
    mtg_res_if.source  o_res
);

    localparam int JW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CW = $clog2(KEY_DEPTH + 1);
    localparam int MAXK = (KEY_DEPTH > 624) ? KEY_DEPTH : 624;
    localparam int KW = $clog2(MAXK + 1);
    localparam int IW = mtg_pkg::IDX_W;

    mtg_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_i, n_i;
    logic [JW-1:0] r_j, n_j;
    logic [KW-1:0] r_k, n_k;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_count, n_count;
    logic          r_pass, n_pass;
    logic [31:0]   r_prev, n_prev;
    logic [31:0]   r_mul, n_mul;
    logic          r_a, n_a;
    logic [31:0]   r_b, n_b;
    logic [IW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_word, n_out_word;
    logic          r_out_kind, n_out_kind;

    logic          st_we;
    logic [IW-1:0] st_waddr;
    logic [31:0]   st_wdata;
    logic [IW-1:0] st_raddr;
    logic [31:0]   st_rdata;
    logic          key_we;
    logic [JW-1:0] key_waddr;
    logic [31:0]   key_rdata;
    logic [31:0]   tempered;

    logic          accept;
    logic          out_free;
    logic [31:0]   y;
    logic [31:0]   mix_val;
    logic [CW-1:0] j_inc;
    logic [KW-1:0] len_k;
    logic [IW:0]   i_plus_m;

    mtg_ram #(.WIDTH(32), .DEPTH(mtg_pkg::MT_N), .AW(IW)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    mtg_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH), .AW(JW)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (i_cmd.data_word),
        .i_raddr (r_j),
        .o_rdata (key_rdata)
    );

    mtg_temper u_temper (
        .i_word (st_rdata),
        .o_word (tempered)
    );

    assign i_cmd.ready       = (r_state == mtg_pkg::ST_IDLE);
    assign accept            = i_cmd.valid && i_cmd.ready;
    assign out_free          = !r_out_valid || o_res.ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.result_word = r_out_word;
    assign o_res.result_kind = r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtg_pkg::ST_IDLE;
            r_pos       <= IW'(mtg_pkg::MT_N);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_len      <= n_len;
        r_pass     <= n_pass;
        r_prev     <= n_prev;
        r_mul      <= n_mul;
        r_a        <= n_a;
        r_b        <= n_b;
        r_idx      <= n_idx;
        r_out_word <= n_out_word;
        r_out_kind <= n_out_kind;
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_len       = r_len;
        n_count     = r_count;
        n_pass      = r_pass;
        n_prev      = r_prev;
        n_mul       = r_mul;
        n_a         = r_a;
        n_b         = r_b;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_word  = r_out_word;
        n_out_kind  = r_out_kind;

        st_we     = 1'b0;
        st_waddr  = r_i;
        st_wdata  = 32'd0;
        st_raddr  = r_i;
        key_we    = 1'b0;
        key_waddr = r_count[JW-1:0];

        y        = {r_a, r_b[30:0]};
        mix_val  = r_pass ? ((st_rdata ^ r_mul) - 32'(r_i))
                          : ((st_rdata ^ r_mul) + key_rdata + 32'(r_j));
        j_inc    = CW'(r_j) + CW'(1);
        len_k    = KW'(r_len);
        i_plus_m = (IW + 1)'(r_i) + (IW + 1)'(mtg_pkg::MT_M);

        case (r_state)
            mtg_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.command)
                        mtg_pkg::CMD_KEY: begin
                            if (r_count != CW'(KEY_DEPTH)) begin
                                key_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                n_len   = r_count + CW'(1);
                            end else begin
                                n_len = r_count;
                            end
                            if (i_cmd.key_last) begin
                                n_count  = '0;
                                st_we    = 1'b1;
                                st_waddr = '0;
                                st_wdata = mtg_pkg::BASE_SEED;
                                n_prev   = mtg_pkg::BASE_SEED;
                                n_i      = IW'(1);
                                n_state  = mtg_pkg::ST_FILL_MUL;
                            end
                        end
                        mtg_pkg::CMD_GEN: begin
                            if (r_pos >= IW'(mtg_pkg::MT_N)) begin
                                n_i     = '0;
                                n_state = mtg_pkg::ST_TW_RD0;
                            end else begin
                                n_state = mtg_pkg::ST_GEN_RD;
                            end
                        end
                        mtg_pkg::CMD_WRITE: begin
                            if (i_cmd.state_index < IW'(mtg_pkg::MT_N)) begin
                                st_we    = 1'b1;
                                st_waddr = i_cmd.state_index;
                                st_wdata = i_cmd.data_word;
                            end else if (i_cmd.state_index == IW'(mtg_pkg::MT_N)) begin
                                n_pos = (i_cmd.data_word > 32'(mtg_pkg::MT_N))
                                      ? IW'(mtg_pkg::MT_N) : i_cmd.data_word[IW-1:0];
                            end
                        end
                        default: begin
                            n_idx   = i_cmd.state_index;
                            n_state = mtg_pkg::ST_READ_RD;
                        end
                    endcase
                end
            end
            mtg_pkg::ST_FILL_MUL: begin
                n_mul   = 32'(mtg_pkg::scramble(r_prev) * mtg_pkg::FILL_MULT);
                n_state = mtg_pkg::ST_FILL_WR;
            end
            mtg_pkg::ST_FILL_WR: begin
                st_we    = 1'b1;
                st_wdata = r_mul + 32'(r_i);
                n_prev   = r_mul + 32'(r_i);
                if (r_i == IW'(mtg_pkg::MT_N - 1)) begin
                    n_i     = IW'(1);
                    n_j     = '0;
                    n_pass  = 1'b0;
                    n_k     = (len_k > KW'(mtg_pkg::MT_N)) ? len_k : KW'(mtg_pkg::MT_N);
                    n_prev  = mtg_pkg::BASE_SEED;
                    n_state = mtg_pkg::ST_MIX_RD;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = mtg_pkg::ST_FILL_MUL;
                end
            end
            mtg_pkg::ST_MIX_RD: begin
                n_mul   = 32'(mtg_pkg::scramble(r_prev) *
                              (r_pass ? mtg_pkg::MIX2_MULT : mtg_pkg::MIX1_MULT));
                n_state = mtg_pkg::ST_MIX_WR;
            end
            mtg_pkg::ST_MIX_WR: begin
                st_we    = 1'b1;
                st_wdata = mix_val;
                n_prev   = mix_val;
                n_k      = r_k - KW'(1);
                n_j      = (j_inc >= r_len) ? '0 : r_j + JW'(1);
                if (r_i == IW'(mtg_pkg::MT_N - 1)) begin
                    n_i     = IW'(1);
                    n_state = mtg_pkg::ST_MIX_WRAP;
                end else begin
                    n_i = r_i + IW'(1);
                    if (r_k == KW'(1)) begin
                        if (r_pass) begin
                            n_state = mtg_pkg::ST_SEED_END;
                        end else begin
                            n_pass  = 1'b1;
                            n_k     = KW'(mtg_pkg::MT_N - 1);
                            n_state = mtg_pkg::ST_MIX_RD;
                        end
                    end else begin
                        n_state = mtg_pkg::ST_MIX_RD;
                    end
                end
            end
            mtg_pkg::ST_MIX_WRAP: begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = r_prev;
                if (r_k == '0) begin
                    if (r_pass) begin
                        n_state = mtg_pkg::ST_SEED_END;
                    end else begin
                        n_pass  = 1'b1;
                        n_k     = KW'(mtg_pkg::MT_N - 1);
                        n_state = mtg_pkg::ST_MIX_RD;
                    end
                end else begin
                    n_state = mtg_pkg::ST_MIX_RD;
                end
            end
            mtg_pkg::ST_SEED_END: begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = mtg_pkg::WORD0_FINAL;
                n_pos    = IW'(mtg_pkg::MT_N);
                n_state  = mtg_pkg::ST_IDLE;
            end
            mtg_pkg::ST_TW_RD0: begin
                n_state = mtg_pkg::ST_TW_RD1;
            end
            mtg_pkg::ST_TW_RD1: begin
                st_raddr = (r_i == IW'(mtg_pkg::MT_N - 1)) ? '0 : r_i + IW'(1);
                n_a      = st_rdata[31];
                n_state  = mtg_pkg::ST_TW_RD2;
            end
            mtg_pkg::ST_TW_RD2: begin
                st_raddr = (i_plus_m >= (IW + 1)'(mtg_pkg::MT_N))
                         ? IW'(i_plus_m - (IW + 1)'(mtg_pkg::MT_N)) : i_plus_m[IW-1:0];
                n_b      = st_rdata;
                n_state  = mtg_pkg::ST_TW_WR;
            end
            mtg_pkg::ST_TW_WR: begin
                st_we    = 1'b1;
                st_wdata = st_rdata ^ (y >> 1) ^ (y[0] ? mtg_pkg::MATRIX_A : 32'd0);
                if (r_i == IW'(mtg_pkg::MT_N - 1)) begin
                    n_pos   = '0;
                    n_state = mtg_pkg::ST_GEN_RD;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = mtg_pkg::ST_TW_RD0;
                end
            end
            mtg_pkg::ST_GEN_RD: begin
                st_raddr = r_pos;
                n_state  = mtg_pkg::ST_GEN_OUT;
            end
            mtg_pkg::ST_GEN_OUT: begin
                st_raddr = r_pos;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = tempered;
                    n_out_kind  = mtg_pkg::KIND_RANDOM;
                    n_pos       = r_pos + IW'(1);
                    n_state     = mtg_pkg::ST_IDLE;
                end
            end
            mtg_pkg::ST_READ_RD: begin
                st_raddr = r_idx;
                n_state  = mtg_pkg::ST_READ_OUT;
            end
            mtg_pkg::ST_READ_OUT: begin
                st_raddr = r_idx;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = mtg_pkg::KIND_STATE;
                    if (r_idx < IW'(mtg_pkg::MT_N)) begin
                        n_out_word = st_rdata;
                    end else if (r_idx == IW'(mtg_pkg::MT_N)) begin
                        n_out_word = 32'(r_pos);
                    end else begin
                        n_out_word = 32'd0;
                    end
                    n_state = mtg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives key, draw and state-access beats into the MT19937 generator and
// compares every result beat against a cycle-free predictor kept in a
// scoreboard. Key arrays of varied length, overflow past the key store, state
// writes and position writes are mixed with draws under random idling.
// ----------------------------------------------------------------------------

class mt_scoreboard;
    bit [31:0] words[624];
    bit [9:0]  pos;
    bit [31:0] keys[32];
    int        key_n;
    bit [32:0] pending[$];
    int        errors;

    function new();
        pos = 624;
        key_n = 0;
        errors = 0;
    endfunction

    function void fill(bit [31:0] s);
        words[0] = s;
        for (int i = 1; i < 624; i++)
            words[i] = mtg_pkg::FILL_MULT * (words[i-1] ^ (words[i-1] >> 30)) + i;
    endfunction

    function void seed(int len);
        int i, j, k;
        bit [31:0] p;
        i = 1;
        j = 0;
        fill(mtg_pkg::BASE_SEED);
        for (k = (len > 624) ? len : 624; k > 0; k--) begin
            p = words[i-1];
            words[i] = (words[i] ^ ((p ^ (p >> 30)) * mtg_pkg::MIX1_MULT)) + keys[j] + j;
            i++;
            j++;
            if (i >= 624) begin
                words[0] = words[623];
                i = 1;
            end
            if (j >= len) j = 0;
        end
        for (k = 623; k > 0; k--) begin
            p = words[i-1];
            words[i] = (words[i] ^ ((p ^ (p >> 30)) * mtg_pkg::MIX2_MULT)) - i;
            i++;
            if (i >= 624) begin
                words[0] = words[623];
                i = 1;
            end
        end
        words[0] = mtg_pkg::WORD0_FINAL;
        pos = 624;
    endfunction

    function bit [31:0] draw();
        bit [31:0] y;
        if (pos >= 624) begin
            for (int i = 0; i < 624; i++) begin
                y = (words[i] & 32'h8000_0000) | (words[(i+1)%624] & 32'h7fff_ffff);
                words[i] = words[(i+397)%624] ^ (y >> 1)
                         ^ (y[0] ? mtg_pkg::MATRIX_A : 32'd0);
            end
            pos = 0;
        end
        y = words[pos];
        pos++;
        y ^= y >> 11;
        y ^= (y << 7) & mtg_pkg::TEMPER_B;
        y ^= (y << 15) & mtg_pkg::TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    function void note_beat(mtg_pkg::t_cmd c, bit [31:0] d, bit last, bit [9:0] idx);
        case (c)
            mtg_pkg::CMD_KEY: begin
                if (key_n < 32) begin
                    keys[key_n] = d;
                    key_n++;
                end
                if (last) begin
                    if (key_n > 0) seed(key_n);
                    key_n = 0;
                end
            end
            mtg_pkg::CMD_GEN: pending.push_back({mtg_pkg::KIND_RANDOM, draw()});
            mtg_pkg::CMD_WRITE: begin
                if (idx < 624) words[idx] = d;
                else if (idx == 624) pos = (d > 624) ? 10'd624 : d[9:0];
            end
            default: begin
                if (idx < 624) pending.push_back({mtg_pkg::KIND_STATE, words[idx]});
                else if (idx == 624) pending.push_back({mtg_pkg::KIND_STATE, 22'd0, pos});
                else pending.push_back({mtg_pkg::KIND_STATE, 32'd0});
            end
        endcase
    endfunction

    function void check_result(bit [31:0] w, bit kind);
        bit [32:0] e;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h kind %0d", w, kind);
            return;
        end
        e = pending.pop_front();
        if (e[31:0] !== w || e[32] !== kind) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected %h kind %0d, got %h kind %0d",
                         e[31:0], e[32], w, kind);
        end
    endfunction
endclass

module tb_top;
    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;

    mtg_cmd_if cmd_if();
    mtg_res_if res_if();
    mt_scoreboard sb = new();

    mt19937_generator_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cmd_if.valid && cmd_if.ready)
            sb.note_beat(mtg_pkg::t_cmd'(cmd_if.command), cmd_if.data_word,
                         cmd_if.key_last, cmd_if.state_index);
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.result_word, res_if.result_kind);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_beat(mtg_pkg::t_cmd c, bit [31:0] d, bit last, bit [9:0] idx);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= c;
        cmd_if.data_word   <= d;
        cmd_if.key_last    <= last;
        cmd_if.state_index <= idx;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic send_key(int len);
        for (int i = 0; i < len; i++)
            send_beat(mtg_pkg::CMD_KEY, $urandom, i == len - 1, 10'($urandom));
    endtask

    task automatic random_beat();
        int r;
        r = $urandom_range(99);
        if (r < 3) send_key($urandom_range(40, 1));
        else if (r < 60)
            send_beat(mtg_pkg::CMD_GEN, $urandom, 1'($urandom), 10'($urandom));
        else if (r < 70)
            send_beat(mtg_pkg::CMD_WRITE, $urandom, 1'($urandom), 10'($urandom_range(623)));
        else if (r < 75)
            send_beat(mtg_pkg::CMD_WRITE,
                      ($urandom_range(1) ? $urandom : $urandom_range(630)),
                      1'($urandom), 10'd624);
        else if (r < 77)
            send_beat(mtg_pkg::CMD_WRITE, $urandom, 1'($urandom),
                      10'($urandom_range(1023, 625)));
        else if (r < 93)
            send_beat(mtg_pkg::CMD_READ, $urandom, 1'($urandom), 10'($urandom_range(624)));
        else
            send_beat(mtg_pkg::CMD_READ, $urandom, 1'($urandom),
                      10'($urandom_range(1023, 625)));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6000) @(posedge i_clk);
    endtask

    initial begin
        cmd_if.valid       = 1'b0;
        cmd_if.command     = mtg_pkg::CMD_KEY;
        cmd_if.data_word   = '0;
        cmd_if.key_last    = 1'b0;
        cmd_if.state_index = '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(mtg_pkg::CMD_KEY, 32'h0000_0123, 1'b1, 10'd0);
        send_beat(mtg_pkg::CMD_GEN, 32'hffff_ffff, 1'b1, 10'h3ff);
        send_beat(mtg_pkg::CMD_READ, '0, 1'b0, 10'd624);
        send_beat(mtg_pkg::CMD_READ, '0, 1'b0, 10'd0);
        send_beat(mtg_pkg::CMD_READ, '0, 1'b0, 10'd623);
        send_beat(mtg_pkg::CMD_READ, 32'hffff_ffff, 1'b1, 10'h3ff);
        send_key(34);
        send_beat(mtg_pkg::CMD_KEY, 32'hffff_ffff, 1'b0, 10'd0);
        send_beat(mtg_pkg::CMD_KEY, 32'h0, 1'b1, 10'd0);
        send_beat(mtg_pkg::CMD_WRITE, 32'hffff_ffff, 1'b1, 10'd623);
        send_beat(mtg_pkg::CMD_WRITE, 32'd0, 1'b0, 10'd0);
        send_beat(mtg_pkg::CMD_WRITE, 32'hffff_ffff, 1'b0, 10'd624);
        send_beat(mtg_pkg::CMD_READ, '0, 1'b0, 10'd624);
        send_beat(mtg_pkg::CMD_WRITE, 32'd623, 1'b0, 10'd624);
        send_beat(mtg_pkg::CMD_GEN, '0, 1'b0, 10'd0);
        send_beat(mtg_pkg::CMD_GEN, '0, 1'b0, 10'd0);
        send_beat(mtg_pkg::CMD_WRITE, 32'h1234_5678, 1'b0, 10'h3ff);
        send_beat(mtg_pkg::CMD_READ, '0, 1'b0, 10'd623);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 80 : 0;
            snk_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 24 : 0;
            for (int n = 0; n < 160; n++) random_beat();
        end
        cmd_if.valid <= 1'b0;
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
src/mtg_pkg.sv
src/mtg_stream_if.sv
src/mtg_ram.sv
src/mtg_temper.sv
src/mt19937_generator_unit.sv
tb/sv/tb_top.sv
